### design/dynamic_polling_scheduler_assert.svh
// Assertion macros shared by the checkers of the polling scheduler.
// Each macro clocks on clk_i and is disabled while rst_ni is low.
`ifndef DYNAMIC_POLLING_SCHEDULER_ASSERT_SVH
`define DYNAMIC_POLLING_SCHEDULER_ASSERT_SVH

// Plain property, checked at every clock edge out of reset.
`define DPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define DPS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/dps_pkg.sv
// Package of the dynamic polling scheduler: phase, action and request
// codes and the result record. No dependencies.
`default_nettype none

package dps_pkg;

  // Request types
  localparam logic [1:0] REQ_PROCEED  = 2'd0;
  localparam logic [1:0] REQ_EMPTY    = 2'd1;
  localparam logic [1:0] REQ_SERVICED = 2'd2;

  // Actions
  localparam logic [2:0] ACT_NONE      = 3'd0;
  localparam logic [2:0] ACT_IDLE      = 3'd1;
  localparam logic [2:0] ACT_CONNECT   = 3'd2;
  localparam logic [2:0] ACT_POLL      = 3'd3;
  localparam logic [2:0] ACT_FLAG      = 3'd4;
  localparam logic [2:0] ACT_CYCLE_END = 3'd5;

  // Phases
  localparam logic [2:0] PH_START     = 3'd0;
  localparam logic [2:0] PH_CHECK     = 3'd1;
  localparam logic [2:0] PH_SWITCHING = 3'd2;
  localparam logic [2:0] PH_POLLING   = 3'd3;
  localparam logic [2:0] PH_VACATION  = 3'd4;
  localparam logic [2:0] PH_END       = 3'd5;

  localparam logic [4:0] NUM_QUEUES_RST = 5'd16;

  typedef struct packed {
    logic [2:0] action;
    logic [3:0] target_queue;
    logic       flag_value;
    logic [2:0] phase_now;
  } dps_result_t;

endpackage

`default_nettype wire

### design/dps_flag_ram.sv
// Poll flag memory: one write port, two registered read ports.
// Port A forwards a same-cycle write; port B returns the old contents.
`default_nettype none

module dps_flag_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk_i,
  input  logic [AW-1:0] a_addr_i,
  output logic          a_data_o,
  input  logic [AW-1:0] b_addr_i,
  output logic          b_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic          wr_data_i
);

  logic mem [DEPTH];
  logic a_data_q;
  logic b_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (wr_en_i && (wr_addr_i == a_addr_i)) begin
      a_data_q <= wr_data_i;
    end else begin
      a_data_q <= mem[a_addr_i];
    end
    b_data_q <= mem[b_addr_i];
  end

  assign a_data_o = a_data_q;
  assign b_data_o = b_data_q;

endmodule

`default_nettype wire

### design/dps_out_fifo.sv
// Two-entry result buffer between the scheduler core and its consumer.
// Depends on dps_pkg for the result record.
`default_nettype none

module dps_out_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  dps_pkg::dps_result_t data_i,
  output logic                full_o,
  output logic                valid_o,
  input  logic                stall_i,
  output dps_pkg::dps_result_t data_o
);
  import dps_pkg::*;

  dps_result_t entry_q [2];
  logic        wr_q;
  logic        rd_q;
  logic [1:0]  cnt_q;
  logic        pop;

  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign data_o  = entry_q[rd_q];
  assign pop     = valid_o & ~stall_i;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

### design/dynamic_polling_scheduler.sv
// Top level of the dynamic polling scheduler: phase/pointer control, flag
// memory read-modify-write, clearing pass. Uses dps_pkg, dps_flag_ram, dps_out_fifo.
//
//   Channel | Direction | Handshake              | Payload
//   --------+-----------+------------------------+-------------------------------
//   in      | input     | in_valid_i/in_stall_o  | req_type_i, queue_index_i
//   out     | output    | out_valid_o/out_stall_i| action_o, target_queue_o,
//           |           |                        | flag_value_o, phase_now_o
//   cfg     | input     | cfg_valid_i/cfg_ready_o| cfg_data_i (num_queues)
//
// One event per cycle while in_stall_o is low; its result sits in the output
// buffer in the next cycle. The flag memory is read ahead at the next pointer, so
// a check step finds its flag ready; same-address writes are forwarded into that read.
// After reset, and after each num_queues write, a pass over all min(MAX_QUEUES, 31)
// entries of the flag memory holds in_stall_o high.
// in_stall_o also rises when the two-entry output buffer is full.
`default_nettype none

module dynamic_polling_scheduler #(
  parameter int MAX_QUEUES = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] req_type_i,
  input  logic [3:0] queue_index_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] action_o,
  output logic [3:0] target_queue_o,
  output logic       flag_value_o,
  output logic [2:0] phase_now_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [4:0] cfg_data_i
);
  import dps_pkg::*;

  // num_queues is five bits wide, so no more than 31 queues are ever live.
  localparam int EFF   = (MAX_QUEUES < 31) ? MAX_QUEUES : 31;
  localparam int PTR_W = $clog2(EFF);
  localparam int CNT_W = $clog2(EFF + 1);
  localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;

  // Configuration and control state
  logic [4:0]       num_q;
  logic [2:0]       ph_q, ph_d;
  logic [PTR_W-1:0] ptr_q, ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;   // cleared flags among the live queues
  logic             pol_q;          // inversion of stored flags below pol_n_q
  logic [CNT_W-1:0] pol_n_q;

  // Clearing / normalizing pass
  logic             sw_act_q;
  logic [PTR_W-1:0] sw_idx_q;
  logic             sw_dv_q;
  logic [PTR_W-1:0] sw_didx_q;
  logic             pend_q;
  logic             init_q;
  logic             sw_start;
  logic             sw_last;
  logic             sw_wdata;
  logic             busy;

  // Pending empty-report count update
  logic             rep_q;
  logic [PTR_W-1:0] rep_idx_q;
  logic             rep_old;
  logic             rep_inc;

  // Memory ports
  logic [PTR_W-1:0] b_addr;
  logic             rd_a, rd_b;
  logic             wr_en, wr_data;
  logic [PTR_W-1:0] wr_addr;

  // Step logic
  logic             acc;
  logic             cfg_we;
  logic             fifo_full;
  logic [CNT_W-1:0] n_eff;
  logic [CMP_W-1:0] n_c, ptr_c, k_c, pol_n_c, adv_src, adv_sum;
  logic             flag_a;
  logic [2:0]       act;
  logic [3:0]       tgt;
  logic             fv;
  logic             it_we, it_val, it_raw;
  logic [PTR_W-1:0] it_idx;
  logic             rearm, dec, rep_set, do_adv;
  dps_result_t      res, res_out;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  // Clamp num_queues into 1..EFF
  always_comb begin
    if (num_q == 5'd0) begin
      n_eff = CNT_W'(1);
    end else if ({1'b0, num_q} > 6'(EFF)) begin
      n_eff = CNT_W'(EFF);
    end else begin
      n_eff = CNT_W'(num_q);
    end
  end

  assign n_c     = CMP_W'(n_eff);
  assign ptr_c   = CMP_W'(ptr_q);
  assign k_c     = CMP_W'(queue_index_i);
  assign pol_n_c = CMP_W'(pol_n_q);

  assign busy       = sw_act_q | sw_dv_q | pend_q;
  assign in_stall_o = busy | fifo_full;
  assign acc        = in_valid_i & ~in_stall_o;

  // Stored bit to logical flag
  assign flag_a  = rd_a ^ (pol_q & (ptr_c < pol_n_c));
  assign rep_old = rd_b ^ (pol_q & (CMP_W'(rep_idx_q) < pol_n_c));
  assign rep_inc = rep_q & rep_old;

  // Event step
  always_comb begin
    ph_d    = ph_q;
    ptr_d   = ptr_q;
    act     = ACT_NONE;
    tgt     = 4'd0;
    fv      = 1'b0;
    it_we   = 1'b0;
    it_val  = 1'b0;
    it_idx  = ptr_q;
    rearm   = 1'b0;
    dec     = 1'b0;
    rep_set = 1'b0;
    do_adv  = 1'b0;
    adv_src = ptr_c;
    adv_sum = '0;
    if (acc) begin
      if (req_type_i == REQ_PROCEED) begin
        case (ph_q)
          PH_START: begin
            if (cnt_q == n_eff) begin
              // every live flag is clear: idle, re-arm all
              act   = ACT_IDLE;
              rearm = 1'b1;
              ph_d  = PH_VACATION;
            end else begin
              ph_d = PH_CHECK;
            end
          end
          PH_CHECK: begin
            if (ptr_c >= n_c) begin
              // pointer left behind by a smaller num_queues
              ptr_d = '0;
              ph_d  = PH_END;
            end else if (flag_a) begin
              act  = ACT_CONNECT;
              tgt  = ptr_c[3:0];
              ph_d = PH_SWITCHING;
            end else begin
              // skip this queue once and re-arm it
              it_we  = 1'b1;
              it_val = 1'b1;
              act    = ACT_FLAG;
              tgt    = ptr_c[3:0];
              fv     = 1'b1;
              dec    = 1'b1;
              do_adv = 1'b1;
            end
          end
          PH_SWITCHING: begin
            act  = ACT_POLL;
            tgt  = ptr_c[3:0];
            ph_d = PH_POLLING;
          end
          PH_VACATION, PH_END: begin
            act  = ACT_CYCLE_END;
            ph_d = PH_START;
          end
          PH_POLLING: begin
            act = ACT_NONE;
          end
          default: begin
            ph_d = PH_START;
          end
        endcase
      end else if ((req_type_i inside {REQ_EMPTY, REQ_SERVICED}) &&
                   (ph_q == PH_POLLING) && (k_c < n_c)) begin
        if (req_type_i == REQ_EMPTY) begin
          it_we   = 1'b1;
          it_val  = 1'b0;
          it_idx  = k_c[PTR_W-1:0];
          act     = ACT_FLAG;
          tgt     = queue_index_i;
          rep_set = 1'b1;
        end
        do_adv  = 1'b1;
        adv_src = k_c;
      end
    end
    if (do_adv) begin
      adv_sum = adv_src + CMP_W'(1);
      if (adv_sum == n_c) begin
        ptr_d = '0;
        ph_d  = PH_END;
      end else begin
        ptr_d = adv_sum[PTR_W-1:0];
        ph_d  = PH_CHECK;
      end
    end
  end

  assign it_raw = it_val ^ (pol_q & (CMP_W'(it_idx) < pol_n_c));

  // Pass over the memory: init writes ones, later passes fold the inversion in
  assign sw_start = pend_q & ~sw_act_q & ~sw_dv_q;
  assign sw_last  = sw_dv_q & (sw_didx_q == PTR_W'(EFF - 1));
  assign sw_wdata = init_q | (rd_b ^ (pol_q & (CMP_W'(sw_didx_q) < pol_n_c)));

  assign b_addr  = sw_act_q ? sw_idx_q : k_c[PTR_W-1:0];
  assign wr_en   = sw_dv_q | it_we;
  assign wr_addr = sw_dv_q ? sw_didx_q : it_idx;
  assign wr_data = sw_dv_q ? sw_wdata : it_raw;

  // Cleared-flag count
  always_comb begin
    if (sw_start) begin
      cnt_d = '0;
    end else if (sw_dv_q) begin
      cnt_d = cnt_q + CNT_W'(((CMP_W'(sw_didx_q) < n_c) && !sw_wdata) ? 1 : 0);
    end else if (rearm) begin
      cnt_d = '0;
    end else begin
      cnt_d = cnt_q + CNT_W'(rep_inc) - CNT_W'(dec);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q     <= NUM_QUEUES_RST;
      ph_q      <= PH_START;
      ptr_q     <= '0;
      cnt_q     <= '0;
      pol_q     <= 1'b0;
      pol_n_q   <= '0;
      sw_act_q  <= 1'b1;
      sw_idx_q  <= '0;
      sw_dv_q   <= 1'b0;
      sw_didx_q <= '0;
      pend_q    <= 1'b0;
      init_q    <= 1'b1;
      rep_q     <= 1'b0;
    end else begin
      if (cfg_we) begin
        num_q <= cfg_data_i;
      end
      ph_q  <= ph_d;
      ptr_q <= ptr_d;
      cnt_q <= cnt_d;
      rep_q <= rep_set;

      // Hold a new pass pending until the current one drains
      if (cfg_we) begin
        pend_q <= 1'b1;
      end else if (sw_start) begin
        pend_q <= 1'b0;
      end
      if (sw_start) begin
        sw_act_q <= 1'b1;
        sw_idx_q <= '0;
      end else if (sw_act_q) begin
        sw_idx_q <= sw_idx_q + PTR_W'(1);
        if (sw_idx_q == PTR_W'(EFF - 1)) begin
          sw_act_q <= 1'b0;
        end
      end
      sw_dv_q   <= sw_act_q;
      sw_didx_q <= sw_idx_q;

      if (sw_last) begin
        pol_q   <= 1'b0;
        pol_n_q <= n_eff;
        init_q  <= 1'b0;
      end else if (rearm) begin
        pol_q <= ~pol_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rep_set) begin
      rep_idx_q <= it_idx;
    end
  end

  dps_flag_ram #(
    .DEPTH (EFF),
    .AW    (PTR_W)
  ) u_flag_ram (
    .clk_i     (clk_i),
    .a_addr_i  (ptr_d),
    .a_data_o  (rd_a),
    .b_addr_i  (b_addr),
    .b_data_o  (rd_b),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  assign res.action       = act;
  assign res.target_queue = tgt;
  assign res.flag_value   = fv;
  assign res.phase_now    = ph_d;

  dps_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (acc),
    .data_i  (res),
    .full_o  (fifo_full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (res_out)
  );

  assign action_o       = res_out.action;
  assign target_queue_o = res_out.target_queue;
  assign flag_value_o   = res_out.flag_value;
  assign phase_now_o    = res_out.phase_now;

endmodule

`default_nettype wire

### design/dps_checker.sv
// Port-level checker for the dynamic polling scheduler, bound to the top.
// Uses dps_pkg codes and the macros of dynamic_polling_scheduler_assert.svh.
`default_nettype none

`include "dynamic_polling_scheduler_assert.svh"

module dps_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] action_o,
  input logic [3:0] target_queue_o,
  input logic       flag_value_o,
  input logic [2:0] phase_now_o
);
  import dps_pkg::*;

  // A stalled result holds.
  `DPS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(action_o) && $stable(target_queue_o) && $stable(flag_value_o) && $stable(phase_now_o), "stalled result changed")

  // Every accepted transaction leaves a result waiting in the next cycle.
  `DPS_ASSERT_NEXT(a_accept_result, in_valid_i && !in_stall_o, out_valid_o, "accepted transaction produced no result")

  // Actions that move the phase report the phase they lead to.
  `DPS_ASSERT_IMPL(a_action_phase, out_valid_o, (action_o != ACT_CONNECT || phase_now_o == PH_SWITCHING) && (action_o != ACT_POLL || phase_now_o == PH_POLLING) && (action_o != ACT_IDLE || phase_now_o == PH_VACATION) && (action_o != ACT_CYCLE_END || phase_now_o == PH_START), "action and phase disagree")

  // Target and flag fields are zero unless the action uses them.
  `DPS_ASSERT(a_unused_zero, !out_valid_o || ((flag_value_o == 1'b0 || action_o == ACT_FLAG) && (target_queue_o == 4'd0 || action_o == ACT_CONNECT || action_o == ACT_POLL || action_o == ACT_FLAG)), "unused result field not zero")

endmodule

bind dynamic_polling_scheduler dps_checker u_dps_checker (.*);

`default_nettype wire
